>>> rtl/core/dose_pkg.sv
package dose_pkg;

    // Longest literal run before its count is written into the reserved slot.
    localparam int unsigned MAX_RUN = 127;
    // Width of stream positions and of the size limit.
    localparam int unsigned POS_W = 32;
    // Largest number of result transfers that one operation can cause.
    localparam int unsigned PLAN_DEPTH = 8;
    localparam int unsigned IDX_W = $clog2(PLAN_DEPTH);
    localparam int unsigned CNT_W = $clog2(PLAN_DEPTH + 1);

    // Byte-level constants of the delta encoding.
    localparam logic [7:0] VARINT_CONT = 8'h80;
    localparam logic [7:0] COPY_OPCODE = 8'h80;
    localparam logic [3:0] COPY_OFF_FLAG_SHIFT = 4'd0;
    localparam logic [3:0] COPY_LEN_FLAG_SHIFT = 4'd4;

    typedef enum logic [1:0] {
        OP_HEADER  = 2'd0,
        OP_LITERAL = 2'd1,
        OP_COPY    = 2'd2,
        OP_FINISH  = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] header_size;
        logic [7:0]  literal_byte;
        logic [31:0] copy_offset;
        logic [16:0] copy_length;
    } in_t;

    typedef struct packed {
        logic [31:0] write_address;
        logic [7:0]  write_byte;
        logic [31:0] end_position;
        logic        over_limit;
        logic        last_of_run;
    } out_t;

    // Emitter state carried from one operation to the next.
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [6:0]       count;
        logic [POS_W-1:0] slot;
    } state_t;

    // One planned write: either the reserved count slot, or base plus a small offset.
    typedef struct packed {
        logic [7:0]       data;
        logic [IDX_W-1:0] off;
        logic             is_slot;
    } entry_t;

    // All writes caused by one operation.
    typedef struct packed {
        logic [CNT_W-1:0]                 count;
        logic [POS_W-1:0]                 base;
        logic [POS_W-1:0]                 slot;
        logic [POS_W-1:0]                 end_pos;
        logic                             over;
        entry_t [PLAN_DEPTH-1:0]          entries;
    } plan_t;

endpackage

>>> rtl/core/dose_planner.sv
module dose_planner
(
    input  dose_pkg::in_t              item,
    input  dose_pkg::state_t           st,
    input  logic [dose_pkg::POS_W-1:0] size_limit,
    output dose_pkg::plan_t            plan,
    output dose_pkg::state_t           st_next
);

    logic                     close_pend;
    dose_pkg::entry_t         close_e;
    logic [34:0]              hv;
    logic [2:0]               hdr_n;
    dose_pkg::entry_t [dose_pkg::PLAN_DEPTH-1:0] hdr_body;
    logic [7:0]               cp_bytes [6];
    logic [5:0]               cp_nz;
    logic [2:0]               cp_n;
    dose_pkg::entry_t [dose_pkg::PLAN_DEPTH-1:0] cp_body;
    dose_pkg::entry_t [dose_pkg::PLAN_DEPTH-1:0] body;
    logic [6:0]               lit_cnt;
    logic                     lit_close;
    logic [2:0]               advance;
    logic [dose_pkg::POS_W-1:0] end_pos;

    assign close_pend = (st.count != 7'd0);
    assign close_e    = '{data: {1'b0, st.count}, off: '0, is_slot: 1'b1};

    // Header size as a base-128 varint, low group first.
    assign hv = {3'b000, item.header_size};

    always_comb
    begin
        hdr_n = 3'd1 + 3'(hv[34:7] != '0) + 3'(hv[34:14] != '0)
              + 3'(hv[34:21] != '0) + 3'(hv[34:28] != '0);
        hdr_body = '0;
        for (int j = 0; j < 5; j++)
        begin
            hdr_body[j].data    = {(3'(j) < hdr_n - 3'd1), hv[7*j +: 7]};
            hdr_body[j].off     = dose_pkg::IDX_W'(j);
            hdr_body[j].is_slot = 1'b0;
        end
    end

    // Copy: opcode, then only the nonzero offset and length bytes, packed together.
    always_comb
    begin
        logic [2:0] p;
        p = 3'd0;
        for (int i = 0; i < 4; i++)
        begin
            cp_bytes[i] = item.copy_offset[8*i +: 8];
        end
        cp_bytes[4] = item.copy_length[7:0];
        cp_bytes[5] = item.copy_length[15:8];
        for (int i = 0; i < 6; i++)
        begin
            cp_nz[i] = (cp_bytes[i] != 8'h00);
        end
        cp_body = '0;
        cp_body[0].data = dose_pkg::COPY_OPCODE
                        | {4'h0, cp_nz[3:0]} << dose_pkg::COPY_OFF_FLAG_SHIFT
                        | {6'h00, cp_nz[5:4]} << dose_pkg::COPY_LEN_FLAG_SHIFT;
        for (int i = 0; i < 6; i++)
        begin
            if (cp_nz[i])
            begin
                cp_body[p + 3'd1].data = cp_bytes[i];
                cp_body[p + 3'd1].off  = dose_pkg::IDX_W'(p + 3'd1);
                p = p + 3'd1;
            end
        end
        cp_n = p + 3'd1;
    end

    assign lit_cnt   = st.count + 7'd1;
    assign lit_close = (lit_cnt >= 7'(dose_pkg::MAX_RUN));

    always_comb
    begin
        body    = '0;
        advance = 3'd0;
        plan    = '0;
        st_next = st;
        unique case (dose_pkg::op_t'(item.operation))
            dose_pkg::OP_HEADER:
            begin
                body       = hdr_body;
                advance    = hdr_n;
                plan.count = dose_pkg::CNT_W'(close_pend) + dose_pkg::CNT_W'(hdr_n);
            end
            dose_pkg::OP_COPY:
            begin
                body       = cp_body;
                advance    = cp_n;
                plan.count = dose_pkg::CNT_W'(close_pend) + dose_pkg::CNT_W'(cp_n);
            end
            dose_pkg::OP_LITERAL:
            begin
                advance    = close_pend ? 3'd1 : 3'd2;
                plan.count = lit_close ? dose_pkg::CNT_W'(2) : dose_pkg::CNT_W'(1);
            end
            dose_pkg::OP_FINISH:
            begin
                plan.count = dose_pkg::CNT_W'(close_pend);
            end
            default:
            begin
                plan.count = '0;
            end
        endcase

        if (dose_pkg::op_t'(item.operation) == dose_pkg::OP_LITERAL)
        begin
            // The literal goes after the slot when this literal opens the run.
            plan.entries[0].data    = item.literal_byte;
            plan.entries[0].off     = dose_pkg::IDX_W'(!close_pend);
            plan.entries[0].is_slot = 1'b0;
            plan.entries[1].data    = {1'b0, lit_cnt};
            plan.entries[1].off     = '0;
            plan.entries[1].is_slot = 1'b1;
            plan.slot               = close_pend ? st.slot : st.pos;
            st_next.slot            = plan.slot;
            st_next.count           = lit_close ? 7'd0 : lit_cnt;
        end
        else
        begin
            // A pending run count is written ahead of everything else.
            for (int e = 0; e < dose_pkg::PLAN_DEPTH; e++)
            begin
                if (!close_pend)
                begin
                    plan.entries[e] = body[e];
                end
                else if (e == 0)
                begin
                    plan.entries[e] = close_e;
                end
                else
                begin
                    plan.entries[e] = body[e-1];
                end
            end
            plan.slot     = st.slot;
            st_next.count = 7'd0;
        end

        plan.base    = st.pos;
        plan.end_pos = end_pos;
        plan.over    = (size_limit != '0) && (end_pos > size_limit);
        st_next.pos  = end_pos;
    end

    assign end_pos = st.pos + dose_pkg::POS_W'(advance);

endmodule

>>> rtl/core/dose_emitter.sv
module dose_emitter
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  dose_pkg::plan_t   plan,
    output logic              free,
    output logic              out_valid,
    input  logic              out_ready,
    output dose_pkg::out_t    out_data
);

    dose_pkg::plan_t              plan_reg;
    logic                         plan_valid_reg;
    logic [dose_pkg::IDX_W-1:0]   idx_reg;
    logic [dose_pkg::IDX_W-1:0]   idx_next;
    logic                         last;
    logic                         done;
    dose_pkg::entry_t             cur;

    assign cur  = plan_reg.entries[idx_reg];
    assign last = (idx_reg == dose_pkg::IDX_W'(plan_reg.count - dose_pkg::CNT_W'(1)));
    assign done = plan_valid_reg && out_ready && last;
    assign free = !plan_valid_reg || done;
    assign idx_next = idx_reg + dose_pkg::IDX_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plan_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end
        else if (load)
        begin
            plan_valid_reg <= 1'b1;
            idx_reg        <= '0;
        end
        else if (done)
        begin
            plan_valid_reg <= 1'b0;
        end
        else if (plan_valid_reg && out_ready)
        begin
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            plan_reg <= plan;
        end
    end

    assign out_valid              = plan_valid_reg;
    assign out_data.write_address = cur.is_slot ? plan_reg.slot
                                  : plan_reg.base + dose_pkg::POS_W'(cur.off);
    assign out_data.write_byte    = cur.data;
    assign out_data.end_position  = plan_reg.end_pos;
    assign out_data.over_limit    = plan_reg.over;
    assign out_data.last_of_run   = last;

    a_plan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        plan_valid_reg |-> (plan_reg.count != '0))
        else $error("result buffer holds an empty plan");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        plan_valid_reg |-> (dose_pkg::CNT_W'(idx_reg) < plan_reg.count))
        else $error("result index ran past the planned writes");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=> (out_valid && idx_reg == $past(idx_next)))
        else $error("results of one operation were cut short");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("plan loaded over unfinished results");

endmodule

>>> rtl/core/delta_op_stream_emitter_unit.sv
// Delta stream emitter. Each input transfer carries one delta operation (header size,
// literal byte, copy, or finish) and causes zero to eight output transfers, each an
// (address, byte) write into the delta stream, delivered in increasing write order with
// last_of_run set on the final one. A literal that opens a run reserves one count slot;
// the count is written back into that slot when the run reaches 127 bytes or when a
// header, copy or finish closes it. An operation waits in the input register until the
// result buffer can take it, then is planned in full, combinationally, into the result
// buffer, which drives the first result. The result buffer drives one output transfer per
// cycle while out_ready is high. An operation moves from the input register into the result
// buffer in the cycle its predecessor's last result leaves, and the input register takes
// the next input transfer in that same cycle. Operations with one result each therefore
// flow at one per cycle while out_ready is high; an operation with N results holds the
// output until all N have transferred. A finish with no pending run produces no output and
// loads nothing. The size limit register is written through the configuration channel,
// which is always ready; it should only be changed while no operation is in flight.
module delta_op_stream_emitter_unit
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  dose_pkg::in_t    in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output dose_pkg::out_t   out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [31:0]      cfg_data
);

    // Input register: holds one operation until the result buffer can take its plan.
    dose_pkg::in_t              in_reg;
    logic                       in_valid_reg;

    // Stream state: next free position, pending run length and its reserved slot.
    dose_pkg::state_t           st_reg;
    dose_pkg::state_t           st_next;

    logic [dose_pkg::POS_W-1:0] size_limit_reg;

    dose_pkg::plan_t            plan;
    logic                       emit_free;
    logic                       consume;
    logic                       load;

    // An operation leaves the input register when the result buffer is empty or
    // is handing over its final result in this cycle.
    assign consume  = in_valid_reg && emit_free;
    assign load     = consume && (plan.count != '0);
    assign in_ready = !in_valid_reg || consume;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg <= in_data;
        end
    end

    // The state advances once per operation, at the moment its plan is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (consume)
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_limit_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            size_limit_reg <= cfg_data;
        end
    end

    // Combinational planning of every write that the operation causes.
    dose_planner u_planner
    (
        .item       (in_reg),
        .st         (st_reg),
        .size_limit (size_limit_reg),
        .plan       (plan),
        .st_next    (st_next)
    );

    // Result buffer and output sequencer.
    dose_emitter u_emitter
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .plan      (plan),
        .free      (emit_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
